// ===== rtl/core/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Command format between the front and back parts, configuration record,
// register indexes and status codes.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned LenW            = 11;
  localparam int unsigned StatusW         = 3;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned MaxFrameDefault = 1000;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgDelimiter   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEscape      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeDelim   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeEscape  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMainProto   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgExtraProto  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMeterAddr   = 3'd6;

  // Register reset values
  localparam logic [ByteW-1:0] DelimiterReset  = 8'h7E;
  localparam logic [ByteW-1:0] EscapeReset     = 8'h7D;
  localparam logic [ByteW-1:0] CodeDelimReset  = 8'h5E;
  localparam logic [ByteW-1:0] CodeEscapeReset = 8'h5D;
  localparam logic [ByteW-1:0] MainProtoReset  = 8'h00;
  localparam logic [ByteW-1:0] ExtraProtoReset = 8'h01;
  localparam logic [ByteW-1:0] MeterAddrReset  = 8'h00;

  // Frame status codes
  localparam logic [StatusW-1:0] StOk    = 3'd0;
  localparam logic [StatusW-1:0] StProto = 3'd1;
  localparam logic [StatusW-1:0] StCsum  = 3'd2;
  localparam logic [StatusW-1:0] StAddr  = 3'd3;
  localparam logic [StatusW-1:0] StLong  = 3'd4;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [1:0] {
    CmdOpen,
    CmdData,
    CmdClose,
    CmdLong
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [ByteW-1:0] data;
    logic             esc_pending;
    logic             proto_ok;
    logic [LenW-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] delimiter;
    logic [ByteW-1:0] escape;
    logic [ByteW-1:0] code_delim;
    logic [ByteW-1:0] code_escape;
    logic [ByteW-1:0] main_proto;
    logic [ByteW-1:0] extra_proto;
    logic [ByteW-1:0] meter_addr;
  } cfg_t;

endpackage

// ===== rtl/core/escaped_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver: byte-stuffed frame deframer with XOR checksum
// Hunts for the delimiter, undoes escape pairs, passes decoded payload bytes
// on and reports a status for each frame.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | request   | in_valid_i / in_ready_o  | line_byte_i
//  out     | result    | out_valid_o / out_ready_i| item_kind_o, payload_byte_o,
//          |           |                          | frame_status_o, frame_length_o
//  cfg     | write     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One line byte is taken every cycle while the queue has room; the classifier is
//  combinational, so the command is written into the queue at the accepting edge
//  and moved into the output register as soon as that register is free or being
//  read. Results leave one per cycle while out_ready_i is high.
//  The two-entry command queue fills only while the result side stalls;
//  in_ready_o drops when it is full and rises in the cycle after the result side
//  frees a slot.
//  Reset clears the frame state and loads the register defaults; no sweep.
//  The configuration port is always ready.
//
module escaped_frame_receiver import efr_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   line_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               item_kind_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [StatusW-1:0] frame_status_o,
  output logic [LenW-1:0]    frame_length_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  cmd_t q_push_cmd, q_pop_cmd;

  assign cfg_ready_o = 1'b1;

  // Register file: writes beyond the last index are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDelimiter:  cfg_d.delimiter   = cfg_data_i;
        CfgEscape:     cfg_d.escape      = cfg_data_i;
        CfgCodeDelim:  cfg_d.code_delim  = cfg_data_i;
        CfgCodeEscape: cfg_d.code_escape = cfg_data_i;
        CfgMainProto:  cfg_d.main_proto  = cfg_data_i;
        CfgExtraProto: cfg_d.extra_proto = cfg_data_i;
        CfgMeterAddr:  cfg_d.meter_addr  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{delimiter:   DelimiterReset,
                 escape:      EscapeReset,
                 code_delim:  CodeDelimReset,
                 code_escape: CodeEscapeReset,
                 main_proto:  MainProtoReset,
                 extra_proto: ExtraProtoReset,
                 meter_addr:  MeterAddrReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify each line byte into a command
  efr_front #(
    .MaxFrame (MaxFrame)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .line_byte_i  (line_byte_i),
    .q_ready_i    (q_push_ready),
    .push_valid_o (q_push_valid),
    .push_cmd_o   (q_push_cmd)
  );

  // Hold commands while the result side stalls
  efr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_cmd_i   (q_push_cmd),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_cmd_o    (q_pop_cmd)
  );

  // Back: advance checksum and address check, register the result
  efr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .meter_addr_i   (cfg_q.meter_addr),
    .pop_valid_i    (q_pop_valid),
    .pop_ready_o    (q_pop_ready),
    .pop_cmd_i      (q_pop_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_status_o (frame_status_o),
    .frame_length_o (frame_length_o)
  );

endmodule

// ===== rtl/core/efr_front.sv =====
// ----------------------------------------------------------------------------
// efr_front: line byte classifier
// Hunts for the delimiter, undoes escape pairs, counts raw bytes, checks the
// protocol id and issues one command per byte that needs back-end work.
// ----------------------------------------------------------------------------
module efr_front import efr_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] line_byte_i,
  input  logic             q_ready_i,
  output logic             push_valid_o,
  output cmd_t             push_cmd_o
);

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic            proto_q, proto_d;
  logic [LenW-1:0] raw_q, raw_d;
  logic            accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    in_frame_d   = in_frame_q;
    esc_d        = esc_q;
    proto_d      = proto_q;
    raw_d        = raw_q;
    push_valid_o = 1'b0;
    push_cmd_o   = '{kind: CmdData, data: '0, esc_pending: 1'b0,
                     proto_ok: 1'b0, length: '0};
    if (accept) begin
      if (!in_frame_q) begin
        if (line_byte_i == cfg_i.delimiter) begin
          in_frame_d        = 1'b1;
          esc_d             = 1'b0;
          proto_d           = 1'b0;
          raw_d             = LenW'(1);
          push_valid_o      = 1'b1;
          push_cmd_o.kind   = CmdOpen;
        end
      end else if (line_byte_i == cfg_i.delimiter) begin
        in_frame_d             = 1'b0;
        esc_d                  = 1'b0;
        push_valid_o           = 1'b1;
        push_cmd_o.kind        = CmdClose;
        push_cmd_o.esc_pending = esc_q;
        push_cmd_o.proto_ok    = proto_q;
        push_cmd_o.length      = raw_q + LenW'(1);
      end else if (raw_q >= LenW'(MaxFrame)) begin
        // cut the frame off at the length limit
        in_frame_d          = 1'b0;
        esc_d               = 1'b0;
        push_valid_o        = 1'b1;
        push_cmd_o.kind     = CmdLong;
        push_cmd_o.proto_ok = proto_q;
        push_cmd_o.length   = LenW'(MaxFrame + 1);
      end else begin
        raw_d = raw_q + LenW'(1);
        if (raw_q == LenW'(1)) begin
          proto_d = (line_byte_i == cfg_i.main_proto) ||
                    (line_byte_i == cfg_i.extra_proto);
        end
        if (esc_q) begin
          esc_d           = 1'b0;
          push_valid_o    = 1'b1;
          push_cmd_o.kind = CmdData;
          if (line_byte_i == cfg_i.code_delim) begin
            push_cmd_o.data = cfg_i.delimiter;
          end else if (line_byte_i == cfg_i.code_escape) begin
            push_cmd_o.data = cfg_i.escape;
          end else begin
            push_cmd_o.data = '0;
          end
        end else if (line_byte_i == cfg_i.escape) begin
          esc_d = 1'b1;
        end else begin
          push_valid_o    = 1'b1;
          push_cmd_o.kind = CmdData;
          push_cmd_o.data = line_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      proto_q    <= 1'b0;
      raw_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      proto_q    <= proto_d;
      raw_q      <= raw_d;
    end
  end

endmodule

// ===== rtl/core/efr_queue.sv =====
// ----------------------------------------------------------------------------
// efr_queue: two-entry command queue
// Decouples the classifier from the result formatter.
// ----------------------------------------------------------------------------
module efr_queue import efr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue fill count out of range");

  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");

  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue fill count missed a request");

endmodule

// ===== rtl/core/efr_back.sv =====
// ----------------------------------------------------------------------------
// efr_back: checksum, address check and result formatter
// Runs the XOR checksum and payload count, and registers each result.
// ----------------------------------------------------------------------------
module efr_back import efr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ByteW-1:0]   meter_addr_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  cmd_t               pop_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               item_kind_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [StatusW-1:0] frame_status_o,
  output logic [LenW-1:0]    frame_length_o
);

  // payload count saturates at three: only zero and two matter
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               addr_ok_q, addr_ok_d;
  logic               valid_q, valid_d;
  logic               kind_q, kind_d;
  logic [ByteW-1:0]   pay_q, pay_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               pop;
  logic [ByteW-1:0]   take_byte;
  logic               take;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  // a pending escape before the closing delimiter counts as a zero byte
  assign take      = pop && ((pop_cmd_i.kind == CmdData) ||
                             (pop_cmd_i.kind == CmdClose && pop_cmd_i.esc_pending));
  assign take_byte = (pop_cmd_i.kind == CmdData) ? pop_cmd_i.data : '0;

  always_comb begin
    xor_d     = xor_q;
    cnt_d     = cnt_q;
    addr_ok_d = addr_ok_q;
    if (take) begin
      if (cnt_q == 2'd2) begin
        addr_ok_d = (take_byte == meter_addr_i);
      end
      xor_d = xor_q ^ take_byte;
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (pop && pop_cmd_i.kind == CmdOpen) begin
      xor_d     = '0;
      cnt_d     = '0;
      addr_ok_d = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    kind_d  = kind_q;
    pay_d   = pay_q;
    st_d    = st_q;
    len_d   = len_q;
    if (pop) begin
      case (pop_cmd_i.kind)
        CmdData: begin
          valid_d = 1'b1;
          kind_d  = KindPayload;
          pay_d   = pop_cmd_i.data;
          st_d    = StOk;
          len_d   = '0;
        end
        CmdClose: begin
          valid_d = 1'b1;
          kind_d  = KindStatus;
          pay_d   = '0;
          len_d   = pop_cmd_i.length;
          if (!pop_cmd_i.proto_ok) begin
            st_d = StProto;
          end else if (cnt_d == 2'd0 || xor_d != '0) begin
            st_d = StCsum;
          end else if (!addr_ok_d) begin
            st_d = StAddr;
          end else begin
            st_d = StOk;
          end
        end
        CmdLong: begin
          valid_d = 1'b1;
          kind_d  = KindStatus;
          pay_d   = '0;
          st_d    = pop_cmd_i.proto_ok ? StLong : StProto;
          len_d   = pop_cmd_i.length;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q     <= '0;
      cnt_q     <= '0;
      addr_ok_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      xor_q     <= xor_d;
      cnt_q     <= cnt_d;
      addr_ok_q <= addr_ok_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pay_q  <= pay_d;
    st_q   <= st_d;
    len_q  <= len_d;
  end

  assign out_valid_o    = valid_q;
  assign item_kind_o    = kind_q;
  assign payload_byte_o = pay_q;
  assign frame_status_o = st_q;
  assign frame_length_o = len_q;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the escaped frame receiver
// Drives raw line bytes and register writes through valid/ready channels,
// predicts every decoded byte and frame status on the side and checks each
// result in order. A short scripted part comes first, then random frames
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import efr_pkg::*;

  localparam int unsigned ClkHalf        = 6;
  localparam int unsigned MaxFrame       = MaxFrameDefault;
  // settling margin after the last awaited result has come out
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned SinkHoldCycles = 60;
  localparam int unsigned WatchdogCycles = 200000;
  // index beyond the register map: a write to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int unsigned ScriptLen      = 27;

  // one result of the block
  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   data;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    length;
  } rx_item_t;

  // one line of the scripted part; when fixed, the result is typed in
  typedef struct packed {
    logic [ByteW-1:0] raw;
    logic             fixed;
    logic             has;
    rx_item_t         item;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ByteW-1:0]   line_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               item_kind_o;
  logic [ByteW-1:0]   payload_byte_o;
  logic [StatusW-1:0] frame_status_o;
  logic [LenW-1:0]    frame_length_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  escaped_frame_receiver #(
    .MaxFrame(MaxFrame)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_byte_i   (line_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .item_kind_o   (item_kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_status_o(frame_status_o),
    .frame_length_o(frame_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shadow of the receiver: register copy and frame state
  // --------------------------------------------------------------------------
  cfg_t        link_cfg;
  logic        fr_open;      // a frame has been opened by a delimiter
  logic        fr_esc;       // escape seen, code byte outstanding
  logic        fr_proto_ok;
  logic        fr_addr_ok;
  logic [7:0]  fr_xor;       // XOR of every decoded byte of the frame
  int unsigned fr_decoded;
  int unsigned fr_raw;       // raw bytes so far, opening delimiter included

  rx_item_t    awaited[$];   // decoded bytes and statuses still to come out
  int unsigned framed_bytes; // requests that the frame logic actually consumed
  int unsigned mismatches;

  bit          source_idles;
  bit          sink_idles;
  bit          sink_hold_req;

  // Fold one decoded byte into checksum, count and address check.
  function automatic void absorb(input logic [7:0] d);
    if (fr_decoded == 2) fr_addr_ok = (d == link_cfg.meter_addr);
    fr_xor ^= d;
    fr_decoded++;
  endfunction

  // Advance the shadow by one raw byte; return whether it yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output rx_item_t res);
    logic [7:0]  d;
    int unsigned pos;
    res        = '0;
    res.kind   = KindPayload;
    res.status = StOk;
    // hunting: only a delimiter matters
    if (!fr_open) begin
      if (b == link_cfg.delimiter) begin
        fr_open     = 1'b1;
        fr_esc      = 1'b0;
        fr_proto_ok = 1'b0;
        fr_addr_ok  = 1'b0;
        fr_xor      = 8'h00;
        fr_decoded  = 0;
        fr_raw      = 1;
      end
      return 1'b0;
    end
    // closing delimiter; a dangling escape still counts as a zero byte
    if (b == link_cfg.delimiter) begin
      if (fr_esc) absorb(8'h00);
      res.kind   = KindStatus;
      res.length = LenW'(fr_raw + 1);
      if (!fr_proto_ok)                          res.status = StProto;
      else if (fr_decoded == 0 || fr_xor != 0)   res.status = StCsum;
      else if (!fr_addr_ok)                      res.status = StAddr;
      else                                       res.status = StOk;
      fr_open = 1'b0;
      fr_esc  = 1'b0;
      return 1'b1;
    end
    // overrun: drop the byte, report and go back to hunting
    pos = fr_raw;
    if (pos >= MaxFrame) begin
      fr_open    = 1'b0;
      fr_esc     = 1'b0;
      res.kind   = KindStatus;
      res.status = fr_proto_ok ? StLong : StProto;
      res.length = LenW'(MaxFrame + 1);
      return 1'b1;
    end
    fr_raw = pos + 1;
    // the protocol id is judged on the raw byte, escape or not
    if (pos == 1)
      fr_proto_ok = (b == link_cfg.main_proto) || (b == link_cfg.extra_proto);
    if (fr_esc) begin
      fr_esc = 1'b0;
      if (b == link_cfg.code_delim)       d = link_cfg.delimiter;
      else if (b == link_cfg.code_escape) d = link_cfg.escape;
      else                                d = 8'h00;
    end else if (b == link_cfg.escape) begin
      fr_esc = 1'b1;
      return 1'b0;
    end else begin
      d = b;
    end
    absorb(d);
    res.data = d;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Script row builders
  function automatic dir_row_t row_silent(input logic [7:0] raw);
    dir_row_t r;
    r       = '0;
    r.raw   = raw;
    r.fixed = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row_data(input logic [7:0] raw, input logic [7:0] d);
    dir_row_t r;
    r           = row_silent(raw);
    r.has       = 1'b1;
    r.item.kind = KindPayload;
    r.item.data = d;
    return r;
  endfunction

  function automatic dir_row_t row_status(input logic [7:0] raw,
                                          input logic [StatusW-1:0] st,
                                          input int unsigned len);
    dir_row_t r;
    r             = row_silent(raw);
    r.has         = 1'b1;
    r.item.kind   = KindStatus;
    r.item.status = st;
    r.item.length = LenW'(len);
    return r;
  endfunction

  function automatic dir_row_t row_predicted(input logic [7:0] raw);
    dir_row_t r;
    r     = '0;
    r.raw = raw;
    return r;
  endfunction

  // Random register set; when tidy, keep framing and escaping unambiguous.
  function automatic cfg_t pick_settings(input bit tidy);
    cfg_t c;
    do begin
      c.delimiter   = rand_byte();
      c.escape      = rand_byte();
      c.code_delim  = rand_byte();
      c.code_escape = rand_byte();
      c.main_proto  = rand_byte();
      c.extra_proto = rand_byte();
      c.meter_addr  = rand_byte();
    end while (tidy && (c.delimiter == c.escape || c.code_delim == c.code_escape ||
                        c.code_delim == c.delimiter || c.code_escape == c.delimiter ||
                        c.main_proto == c.delimiter || c.extra_proto == c.delimiter));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  initial begin
    #(WatchdogCycles * 2 * ClkHalf);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus a long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        hold_left     = SinkHoldCycles;
        sink_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(sink_idles && $urandom_range(0, 99) < 20);
      end
    end
  end

  // Compare one field; X or Z on the port counts as a mismatch.
  function automatic void compare_field(input string name, input logic [LenW-1:0] want,
                                        input logic [LenW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check every accepted result against the oldest one awaited.
  always @(posedge clk_i) begin : result_check
    rx_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: kind %0d, byte 0x%0h, status %0d, length %0d",
               item_kind_o, payload_byte_o, frame_status_o, frame_length_o);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        compare_field("item_kind",    LenW'(want.kind),   LenW'(item_kind_o));
        compare_field("payload_byte", LenW'(want.data),   LenW'(payload_byte_o));
        compare_field("frame_status", LenW'(want.status), LenW'(frame_status_o));
        compare_field("frame_length", want.length,        frame_length_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one line byte, hold it until taken, then log what it should yield.
  task automatic offer_row(input dir_row_t r);
    rx_item_t got;
    bit       fires;
    bit       was_open;
    // drop valid now and then
    if (source_idles && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_byte_i <= r.raw;
    do @(posedge clk_i); while (!in_ready_o);
    was_open = fr_open;
    fires    = deframe_byte(r.raw, got);
    if (was_open || fr_open) framed_bytes++;
    // typed-in rows override the shadow, which still advances
    if (r.fixed) begin
      fires = r.has;
      got   = r.item;
    end
    if (fires) awaited.push_back(got);
  endtask

  task automatic offer_byte(input logic [7:0] b);
    offer_row(row_predicted(b));
  endtask

  // Send one decoded byte with escaping under the current registers.
  task automatic offer_stuffed(input logic [7:0] d);
    if (d == link_cfg.delimiter) begin
      offer_byte(link_cfg.escape);
      offer_byte(link_cfg.code_delim);
    end else if (d == link_cfg.escape) begin
      offer_byte(link_cfg.escape);
      offer_byte(link_cfg.code_escape);
    end else begin
      offer_byte(d);
    end
  endtask

  // Lower valid, wait until every result is out, then let the pipe settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDelimiter:  link_cfg.delimiter   = val;
      CfgEscape:     link_cfg.escape      = val;
      CfgCodeDelim:  link_cfg.code_delim  = val;
      CfgCodeEscape: link_cfg.code_escape = val;
      CfgMainProto:  link_cfg.main_proto  = val;
      CfgExtraProto: link_cfg.extra_proto = val;
      CfgMeterAddr:  link_cfg.meter_addr  = val;
      default: ;
    endcase
  endtask

  // Load the full register set, plus one stray write that must be dropped.
  task automatic program_regs(input cfg_t c);
    write_reg(CfgDelimiter,  c.delimiter);
    write_reg(CfgEscape,     c.escape);
    write_reg(CfgCodeDelim,  c.code_delim);
    write_reg(CfgCodeEscape, c.code_escape);
    write_reg(CfgMainProto,  c.main_proto);
    write_reg(CfgExtraProto, c.extra_proto);
    write_reg(CfgMeterAddr,  c.meter_addr);
    write_reg(CfgUnused,     rand_byte());
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly well-formed frames, some line noise, some junk.
  task automatic random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  body[$];
    logic [7:0]  sum;
    start = framed_bytes;
    while (framed_bytes - start < budget) begin
      pick = $urandom_range(0, 99);
      body.delete();
      if (pick < 70) begin
        // well-formed frame: id, payload, address in byte three, checksum last
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (k = 0; k < n; k++) begin
          if (k == 0) begin
            case ($urandom_range(0, 3))
              0, 2:    body.push_back(link_cfg.main_proto);
              1:       body.push_back(link_cfg.extra_proto);
              default: body.push_back(rand_byte());
            endcase
          end else if (k == 2 && $urandom_range(0, 3) != 0) begin
            body.push_back(link_cfg.meter_addr);
          end else begin
            body.push_back(rand_byte());
          end
        end
        if (n > 0) begin
          sum = 8'h00;
          for (k = 0; k + 1 < n; k++) sum ^= body[k];
          body[n-1] = sum;
          // spoil one byte now and then
          if ($urandom_range(0, 9) == 0)
            body[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        offer_byte(link_cfg.delimiter);
        foreach (body[i]) offer_stuffed(body[i]);
        // leave an escape hanging before the close
        if ($urandom_range(0, 9) == 0) offer_byte(link_cfg.escape);
        offer_byte(link_cfg.delimiter);
      end else if (pick < 85) begin
        // line noise, biased towards the framing bytes
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 5))
            0:       offer_byte(link_cfg.delimiter);
            1:       offer_byte(link_cfg.escape);
            default: offer_byte(rand_byte());
          endcase
        end
      end else begin
        // broken frame: escapes followed by arbitrary codes
        offer_byte(link_cfg.delimiter);
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 4))
            0:       offer_byte(link_cfg.escape);
            1:       offer_byte(link_cfg.code_delim);
            2:       offer_byte(link_cfg.code_escape);
            default: offer_byte(rand_byte());
          endcase
        end
        offer_byte(link_cfg.delimiter);
      end
    end
  endtask

  // Frame that never closes: the byte at the size limit gets cut off.
  task automatic overlong_frame();
    logic [7:0]  b;
    int unsigned k;
    offer_byte(link_cfg.delimiter);
    offer_byte(link_cfg.main_proto);
    for (k = 2; k <= MaxFrame; k++) begin
      do b = rand_byte(); while (b == link_cfg.delimiter);
      offer_byte(b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t script [ScriptLen];
    cfg_t     home_cfg;
    cfg_t     edge_hi;
    cfg_t     edge_lo;

    home_cfg = '{DelimiterReset, EscapeReset, CodeDelimReset, CodeEscapeReset,
                 MainProtoReset, ExtraProtoReset, MeterAddrReset};
    edge_hi  = '{8'hFF, 8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'hFF};
    edge_lo  = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h00};

    // shadow starts from its reset state
    link_cfg      = home_cfg;
    fr_open       = 1'b0;
    fr_esc        = 1'b0;
    fr_proto_ok   = 1'b0;
    fr_addr_ok    = 1'b0;
    fr_xor        = 8'h00;
    fr_decoded    = 0;
    fr_raw        = 0;
    framed_bytes  = 0;
    mismatches    = 0;
    source_idles  = 1'b1;
    sink_idles    = 1'b1;
    sink_hold_req = 1'b0;

    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    line_byte_i <= 8'h00;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgDelimiter;
    cfg_data_i  <= 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted part, reset registers
    script = '{
      row_silent(8'hFF),                          // hunting: ignored
      row_silent(DelimiterReset),                 // open
      row_status(DelimiterReset, StProto, 2),     // empty frame
      row_silent(DelimiterReset),
      row_data  (8'h01, 8'h01),                   // extra protocol id
      row_silent(EscapeReset),
      row_data  (CodeDelimReset, DelimiterReset), // escaped delimiter
      row_data  (8'h00, 8'h00),                   // address byte
      row_silent(EscapeReset),
      row_data  (CodeEscapeReset, EscapeReset),   // escaped escape
      row_silent(EscapeReset),
      row_data  (8'h33, 8'h00),                   // unknown code gives zero
      row_data  (8'h02, 8'h02),                   // checksum byte
      row_predicted(DelimiterReset),              // good frame
      row_silent(DelimiterReset),
      row_data  (8'h00, 8'h00),
      row_data  (8'h00, 8'h00),
      row_status(DelimiterReset, StAddr, 4),      // too short for an address
      row_silent(DelimiterReset),
      row_data  (8'h01, 8'h01),
      row_data  (8'hFF, 8'hFF),
      row_status(DelimiterReset, StCsum, 4),
      row_silent(DelimiterReset),
      row_silent(EscapeReset),                    // escape in the id slot
      row_data  (CodeDelimReset, DelimiterReset),
      row_silent(EscapeReset),                    // escape left hanging
      row_status(DelimiterReset, StProto, 5)
    };
    foreach (script[i]) offer_row(script[i]);
    settle();

    // Reset values written back explicitly
    program_regs(home_cfg);
    random_traffic(80);
    settle();

    // Extreme settings
    program_regs(edge_hi);
    random_traffic(80);
    settle();
    program_regs(edge_lo);
    random_traffic(80);
    settle();

    // No idling at all; stall the result side so the queue fills
    source_idles  = 1'b0;
    sink_idles    = 1'b0;
    program_regs(pick_settings(1'b1));
    sink_hold_req = 1'b1;
    random_traffic(80);
    settle();

    // Frame past the size limit, with a hold in the middle of it
    source_idles = 1'b1;
    sink_idles   = 1'b1;
    program_regs(pick_settings(1'b1));
    sink_hold_req = 1'b1;
    overlong_frame();
    random_traffic(40);
    settle();

    // Any register values, clashes included
    program_regs(pick_settings(1'b0));
    random_traffic(80);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
